// ----- design/spiq_pkg.sv -----
package spiq_pkg;

  localparam int PRIO_BITS = 32;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DRAIN
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_ENTRY  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    OPC_INSERT = 1'b0,
    OPC_DRAIN  = 1'b1
  } opcode_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  typedef struct packed {
    cell_op_t                      op;
    logic signed [PRIO_BITS-1:0]   prio;
  } cell_cmd_t;

  typedef struct packed {
    logic                          valid;
    logic                          shift;
    logic                          ge;
    logic signed [PRIO_BITS-1:0]   prio;
  } cell_link_t;

endpackage

// ----- design/spiq_cell.sv -----
module spiq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spiq_pkg::cell_cmd_t   cmd,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  spiq_pkg::cell_link_t  left_link,
  input  logic [TAG_BITS-1:0]   left_tag,
  input  spiq_pkg::cell_link_t  right_link,
  input  logic [TAG_BITS-1:0]   right_tag,
  output spiq_pkg::cell_link_t  link,
  output logic [TAG_BITS-1:0]   tag
);
  import spiq_pkg::*;

  logic                        valid_r, valid_nxt;
  logic [TAG_BITS-1:0]         tag_r, tag_nxt;
  logic signed [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                        ge, eq, shift, take_new;

  always_comb begin
    ge       = valid_r && ($signed(prio_r) >= $signed(cmd.prio));
    eq       = valid_r && (prio_r == cmd.prio);
    // an equal entry keeps its place only if it is the first one not smaller
    shift    = ge && !(eq && !left_link.ge);
    take_new = !left_link.shift && (shift || !valid_r) && left_link.valid;

    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (left_link.shift) begin
          valid_nxt = 1'b1;
          tag_nxt   = left_tag;
          prio_nxt  = left_link.prio;
        end else if (take_new) begin
          valid_nxt = 1'b1;
          tag_nxt   = new_tag;
          prio_nxt  = cmd.prio;
        end
      end
      CELL_DRAIN: begin
        valid_nxt = right_link.valid;
        tag_nxt   = right_tag;
        prio_nxt  = right_link.prio;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign link.valid = valid_r;
  assign link.shift = shift;
  assign link.ge    = ge;
  assign link.prio  = prio_r;
  assign tag        = tag_r;

endmodule

// ----- design/sorted_insert_priority_queue.sv -----
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall   opcode, job_tag, priority_req
// out_     output     out_valid / out_stall job_tag, priority, status, last
//
// An insert has every cell compare with the new priority at once, and the row
// shifts right from the insertion point. A drain emits one entry per cycle from
// the head cell while the row shifts left, unless out_stall holds the output; no
// new transfer is taken until the last entry is registered. Results sit in one
// output register; a stall holds it and holds off the next input.
// Reset clears the cell valid bits, the state, the count and the output valid.
module sorted_insert_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [TAG_BITS-1:0]            in_job_tag,
  input  logic signed [31:0]             in_priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [TAG_BITS-1:0]            out_job_tag,
  output logic signed [31:0]             out_priority,
  output logic [1:0]                     out_status,
  output logic                           out_last
);
  import spiq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [TAG_BITS-1:0]         out_tag_r, out_tag_nxt;
  logic signed [31:0]          out_prio_r, out_prio_nxt;
  status_t                     out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        can_load;
  cell_cmd_t                   cmd;

  cell_link_t                  links [DEPTH+2];
  logic [TAG_BITS-1:0]         tags  [DEPTH+2];

  // index 0 is the stub left of cell 1, index DEPTH+1 the stub right of the last cell
  assign links[0]       = '{valid: 1'b1, shift: 1'b0, ge: 1'b0, prio: '0};
  assign tags[0]        = '0;
  assign links[DEPTH+1] = '{valid: 1'b0, shift: 1'b0, ge: 1'b0, prio: '0};
  assign tags[DEPTH+1]  = '0;

  for (genvar i = 1; i <= DEPTH; i++) begin : g_cell
    spiq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_tag    (in_job_tag),
      .left_link  (links[i-1]),
      .left_tag   (tags[i-1]),
      .right_link (links[i+1]),
      .right_tag  (tags[i+1]),
      .link       (links[i]),
      .tag        (tags[i])
    );
  end

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_tag_nxt    = out_tag_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    cmd.op         = CELL_HOLD;
    cmd.prio       = in_priority_req;
    in_stall       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_stall = !can_load;
        if (in_valid && can_load) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = '0;
          out_prio_nxt  = '0;
          out_last_nxt  = 1'b1;
          if (opcode_t'(in_opcode) == OPC_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_ACCEPT;
              cmd.op         = CELL_INSERT;
              count_nxt      = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_tag_nxt    = tags[1];
          out_prio_nxt   = links[1].prio;
          out_status_nxt = ST_ENTRY;
          out_last_nxt   = (count_r == CW'(1));
          cmd.op         = CELL_DRAIN;
          count_nxt      = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_job_tag  = out_tag_r;
  assign out_priority = out_prio_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

endmodule
